>>> rtl/btdc_pkg.sv
// package for the bump-and-turn drive controller
// holds widths, register indexes and reset values, manoeuvre and state encodings, control structs, a clamp function
// no dependencies
`default_nettype none

package btdc_pkg;

  // tick counter width and saturation value
  localparam int TICK_BITS = 8;
  localparam logic [TICK_BITS-1:0] TICK_MAX = '1;
  localparam int SAT_W = 17;

  // field widths
  localparam int RAND_W  = 16;
  localparam int MIN_W   = 7;
  localparam int SPAN_W  = 8;
  localparam int INIT_W  = 8;
  localparam int SUM_W   = 9;
  localparam int CNT_W   = $clog2(RAND_W + 1);
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(RAND_W);

  // port widths
  localparam int IN_W   = 24;
  localparam int OUT_W  = 8;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 8;

  // register indexes
  localparam logic [IDX_W-1:0] REG_INIT_FWD = 3'd0;
  localparam logic [IDX_W-1:0] REG_REV_MIN  = 3'd1;
  localparam logic [IDX_W-1:0] REG_REV_SPAN = 3'd2;
  localparam logic [IDX_W-1:0] REG_TRN_MIN  = 3'd3;
  localparam logic [IDX_W-1:0] REG_TRN_SPAN = 3'd4;
  localparam logic [IDX_W-1:0] REG_FWD_MIN  = 3'd5;
  localparam logic [IDX_W-1:0] REG_FWD_SPAN = 3'd6;

  // register reset values
  localparam logic [INIT_W-1:0] RST_INIT_FWD = 8'd50;
  localparam logic [MIN_W-1:0]  RST_REV_MIN  = 7'd10;
  localparam logic [SPAN_W-1:0] RST_REV_SPAN = 8'd11;
  localparam logic [MIN_W-1:0]  RST_TRN_MIN  = 7'd10;
  localparam logic [SPAN_W-1:0] RST_TRN_SPAN = 8'd21;
  localparam logic [MIN_W-1:0]  RST_FWD_MIN  = 7'd40;
  localparam logic [SPAN_W-1:0] RST_FWD_SPAN = 8'd41;

  typedef enum logic [1:0] {
    MV_FORWARD = 2'd0,
    MV_REVERSE = 2'd1,
    MV_LEFT    = 2'd2,
    MV_RIGHT   = 2'd3
  } mv_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } stat_t;

  // clamp a sum to the tick counter range
  function automatic logic [TICK_BITS-1:0] sat_ticks(input logic [SUM_W-1:0] v);
    logic [SAT_W-1:0] ext;
    ext = SAT_W'(v);
    if (ext > SAT_W'(TICK_MAX)) begin
      sat_ticks = TICK_MAX;
    end else begin
      sat_ticks = TICK_BITS'(v);
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/btdc_ctrl.sv
// controller state machine: accept, divide, commit
// depends on btdc_pkg
`default_nettype none

module btdc_ctrl import btdc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DIV;
      ST_DIV:  if (stat.div_done) state_nxt = ST_FIN;
      ST_FIN:  if (stat.out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIV:  cmd.step = !stat.div_done;
      ST_FIN:  cmd.commit = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/btdc_datapath.sv
// datapath: config registers, drive state, bit-serial modulo, output register
// depends on btdc_pkg
`default_nettype none

module btdc_datapath import btdc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [IN_W-1:0]   in_word,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_W-1:0]  cfg_val,
  input  wire cmd_t              cmd,
  output stat_t                  stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [OUT_W-1:0]       out_word
);

  // config registers
  logic [MIN_W-1:0]  rev_min_r, trn_min_r, fwd_min_r;
  logic [SPAN_W-1:0] rev_span_r, trn_span_r, fwd_span_r;

  // drive state
  mv_t                 mv_r, mv_nxt;
  logic [TICK_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [TICK_BITS-1:0] target_r, target_nxt;
  logic                 blue_r, blue_nxt;
  logic                 stop_r, stop_nxt;

  // latched item
  logic              obst_r, batt_r, pick_r;
  logic [RAND_W-1:0] rnd_r;

  // divider
  logic [SPAN_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W-1:0]  shifted;
  logic [SPAN_W-1:0] span_sel, off;
  logic [MIN_W-1:0]  min_sel;
  logic [TICK_BITS-1:0] dur;
  logic              expire;

  // output register
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_r, out_nxt;

  // config writes, index 0 only reloads the target in the drive state block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rev_min_r  <= RST_REV_MIN;
      rev_span_r <= RST_REV_SPAN;
      trn_min_r  <= RST_TRN_MIN;
      trn_span_r <= RST_TRN_SPAN;
      fwd_min_r  <= RST_FWD_MIN;
      fwd_span_r <= RST_FWD_SPAN;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_INIT_FWD: ;
        REG_REV_MIN:  rev_min_r  <= cfg_val[MIN_W-1:0];
        REG_REV_SPAN: rev_span_r <= cfg_val;
        REG_TRN_MIN:  trn_min_r  <= cfg_val[MIN_W-1:0];
        REG_TRN_SPAN: trn_span_r <= cfg_val;
        REG_FWD_MIN:  fwd_min_r  <= cfg_val[MIN_W-1:0];
        REG_FWD_SPAN: fwd_span_r <= cfg_val;
        default: ;
      endcase
    end
  end

  // latch the item on accept, shift the random word on each step
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      obst_r <= in_word[0];
      batt_r <= in_word[1];
      rnd_r  <= in_word[RAND_W+1:2];
      pick_r <= in_word[RAND_W+2];
    end else if (cmd.step) begin
      rnd_r  <= {rnd_r[RAND_W-2:0], 1'b0};
    end
  end

  // which duration the tick needs
  assign expire = elapsed_r >= target_r;
  always_comb begin
    if (obst_r) begin
      span_sel = rev_span_r;
      min_sel  = rev_min_r;
    end else if (mv_r == MV_FORWARD || mv_r == MV_REVERSE) begin
      span_sel = trn_span_r;
      min_sel  = trn_min_r;
    end else begin
      span_sel = fwd_span_r;
      min_sel  = fwd_min_r;
    end
  end

  // restoring modulo, one random bit per step
  assign shifted = {rem_r, rnd_r[RAND_W-1]};
  always_comb begin
    if (shifted >= SUM_W'(span_sel)) begin
      rem_nxt = SPAN_W'(shifted - SUM_W'(span_sel));
    end else begin
      rem_nxt = shifted[SPAN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= '0;
    end else if (cmd.step) begin
      rem_r <= rem_nxt;
    end
  end

  assign off = (span_sel == '0) ? '0 : rem_r;
  assign dur = sat_ticks(SUM_W'(min_sel) + SUM_W'(off));

  // tick update
  always_comb begin
    mv_nxt      = mv_r;
    elapsed_nxt = elapsed_r;
    target_nxt  = target_r;
    blue_nxt    = blue_r;
    stop_nxt    = stop_r;
    if (!stop_r) begin
      if (obst_r) begin
        elapsed_nxt = '0;
        target_nxt  = dur;
        mv_nxt      = MV_REVERSE;
      end else if (batt_r) begin
        stop_nxt = 1'b1;
      end else if (expire) begin
        unique case (mv_r)
          MV_FORWARD: mv_nxt = MV_RIGHT;
          MV_REVERSE: mv_nxt = pick_r ? MV_LEFT : MV_RIGHT;
          default:    mv_nxt = MV_FORWARD;
        endcase
        target_nxt  = dur;
        elapsed_nxt = '0;
      end else begin
        blue_nxt    = !blue_r;
        elapsed_nxt = elapsed_r + TICK_BITS'(1);
      end
    end
  end

  // result word from the updated state
  always_comb begin
    out_nxt = '0;
    if (stop_nxt) begin
      out_nxt[5] = 1'b1;
      out_nxt[6] = 1'b1;
      out_nxt[7] = 1'b1;
    end else begin
      if (!batt_r) begin
        unique case (mv_nxt)
          MV_FORWARD: begin
            out_nxt[0] = 1'b1;
            out_nxt[2] = 1'b1;
          end
          MV_REVERSE: begin
            out_nxt[1] = 1'b1;
            out_nxt[3] = 1'b1;
          end
          MV_LEFT:  out_nxt[2] = 1'b1;
          default:  out_nxt[0] = 1'b1;
        endcase
      end
      out_nxt[4] = 1'b1;
      out_nxt[5] = blue_nxt;
    end
  end

  // drive state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r      <= MV_FORWARD;
      elapsed_r <= '0;
      target_r  <= sat_ticks(SUM_W'(RST_INIT_FWD));
      blue_r    <= 1'b0;
      stop_r    <= 1'b0;
    end else if (cmd.commit) begin
      mv_r      <= mv_nxt;
      elapsed_r <= elapsed_nxt;
      target_r  <= target_nxt;
      blue_r    <= blue_nxt;
      stop_r    <= stop_nxt;
    end else if (cfg_we && cfg_idx == REG_INIT_FWD) begin
      target_r  <= sat_ticks(SUM_W'(cfg_val));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_word      = out_r;
  assign stat.div_done = cnt_r == DIV_STEPS;
  assign stat.out_free = !out_valid_r || out_ready;

endmodule

`default_nettype wire

>>> rtl/bump_and_turn_drive_controller.sv
// top level of the bump-and-turn drive controller
// depends on btdc_pkg, btdc_ctrl, btdc_datapath
//
// channel  dir  handshake                   payload
// in_      in   in_tvalid / in_tready       in_tdata: obstacle, battery_empty, random_word, random_pick
// out_     out  out_tvalid / out_tready     out_tdata: motor pins, clean, leds, halted
// cfg_     in   cfg_valid / cfg_ready       cfg_index, cfg_data
//
// one tick runs from accept through a bit-serial modulo of random_word by the selected span
// to a commit of the new drive state and result word
// the result sits in an output register, so the next tick is taken while it waits
// a stalled output holds the block in its commit state until the word leaves
// rst_n is synchronous and restores the register reset values; cfg is always ready
`default_nettype none

module bump_and_turn_drive_controller import btdc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // [0] obstacle, [1] battery_empty, [17:2] random_word, [18] random_pick, [23:19] zero
  input  wire logic [IN_W-1:0]   in_tdata,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // [0] left_forward, [1] left_reverse, [2] right_forward, [3] right_reverse,
  // [4] clean_motor, [5] blue_led, [6] red_led, [7] halted
  output logic [OUT_W-1:0]       out_tdata,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  btdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  btdc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_tdata),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_val   (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_tdata)
  );

endmodule

`default_nettype wire

>>> rtl/btdc_checker.sv
// port-level checks for the bump-and-turn drive controller, bound to the top level
// depends on btdc_pkg
`default_nettype none

module btdc_checker import btdc_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_W-1:0]  out_tdata
);

  // a halted word shows motors off, cleaning off, both leds on
  a_halt_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[7] |-> out_tdata[6:0] == 7'b1100000)
    else $error("halted word with wrong pins");

  // no motor driven both ways
  a_motor_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]) && !(out_tdata[2] && out_tdata[3]))
    else $error("motor driven forward and reverse");

  // one tick in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a tick is in progress");

  // reset empties the output
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

endmodule

bind bump_and_turn_drive_controller btdc_checker u_btdc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
